// ===== rtl/core/gcd_pkg.sv =====
package gcd_pkg;

  // pi/4 in Q62 (equal to pi in Q60)
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  // degrees*65536 to radians scale: radians per degree in Q62
  localparam logic [63:0] RAD_PER_UNIT = PI_Q60 / 64'd45;

  localparam int DEG_HALF    = 11796480;
  localparam int DEG_FULL    = 23592960;
  localparam int DEG_QUARTER = 5898240;

  // shift-subtract quotient, only evaluated at elaboration
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round half up of a*b / 2^s, kept to 64 bits
  function automatic logic [63:0] mulr(input logic [63:0] a, input logic [63:0] b,
                                       input int s);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] q62_to_f(input logic [63:0] v, input int f);
    return (v + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  // atan(2^-i) in Q62 by the alternating series
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] a;
    logic [63:0] term;
    a = '0;
    if (i == 0) begin
      a = PI_Q60;
    end else begin
      for (int k = 0; i * (2 * k + 1) < 63; k++) begin
        term = div_u64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
        a = (k % 2 == 1) ? a - term : a + term;
      end
    end
    return a;
  endfunction

  // inverse cordic gain in Q62, newton steps of 1/sqrt
  function automatic logic [63:0] gain_q62(input int n);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    p = 64'd1 << 62;
    y = 64'h2666666666666666;
    for (int i = 0; i < n; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (int k = 0; k < 6; k++) begin
      t = mulr(y, y, 62);
      u = mulr(p, t, 62);
      y = mulr(y, (64'd3 << 62) - u, 63);
    end
    return y;
  endfunction

endpackage

// ===== rtl/core/gcd_cordic.sv =====
module gcd_cordic #(
  parameter int F      = 30,
  parameter int N      = 24,
  parameter int W      = 33,
  parameter int TW     = 2,
  parameter bit VECTOR = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_i,
  input  logic [TW-1:0]       tag_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  output logic                vld_o,
  output logic [TW-1:0]       tag_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o
);

  logic signed [W-1:0] x_r [N];
  logic signed [W-1:0] y_r [N];
  logic signed [W-1:0] z_r [N];
  logic [TW-1:0]       t_r [N];
  logic                v_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [W-1:0] AT = W'(gcd_pkg::q62_to_f(gcd_pkg::atan_q62(i), F));
    logic signed [W-1:0] xp, yp, zp;
    logic [TW-1:0]       tp;
    logic                vp;
    logic                pos;

    if (i == 0) begin : g_head
      assign xp = x_i;
      assign yp = y_i;
      assign zp = z_i;
      assign tp = tag_i;
      assign vp = vld_i;
    end else begin : g_link
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign tp = t_r[i-1];
      assign vp = v_r[i-1];
    end

    // rotation follows the sign of z, vectoring drives y toward zero
    assign pos = VECTOR ? !(yp > 0) : !zp[W-1];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (pos) begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - AT;
        end else begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + AT;
        end
        t_r[i] <= tp;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= vp;
      end
    end
  end

  assign x_o   = x_r[N-1];
  assign y_o   = y_r[N-1];
  assign z_o   = z_r[N-1];
  assign tag_o = t_r[N-1];
  assign vld_o = v_r[N-1];

endmodule

// ===== rtl/core/great_circle_distance.sv =====
// great-circle distance by the spherical law of cosines. one beat on in_tdata carries two
// points (lat/lon in signed degrees * 65536); one beat on out_tdata returns
// sphere_radius * central angle in 1/256 distance units. a new beat is taken every cycle
// the output side is not stalled. the pipe runs through angle scaling, the two cordic
// pipelines (one stage per iteration), the dot product and the square root, which resolves
// one root bit per stage. the whole pipe moves as one on out_tready, so a stall freezes
// every stage and nothing is lost or repeated.
// sphere_radius is written on the cfg channel, always ready, and should only change while
// the pipe is empty. identical points give zero.
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS   = 30,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // lat_a[23:0] lon_a[48:24] lat_b[72:49] lon_b[97:73], pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // arc_distance[33:0], pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data    // sphere_radius
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int N  = CORDIC_ITERATIONS;
  localparam int W  = F + 3;        // cordic datapath, signed
  localparam int MW = F + 2;        // operand magnitude for the dot products
  localparam int PW = 2 * MW;
  localparam int SW = 2 * F + 2;    // square root remainder
  localparam int RW = F + 1;        // square root result
  localparam int AW = F + 2;        // central angle, unsigned

  localparam logic signed [W-1:0] GAIN =
    W'(gcd_pkg::q62_to_f(gcd_pkg::gain_q62(N), F));
  localparam logic [AW-1:0] PI_F =
    AW'((gcd_pkg::PI_Q60 + (64'd1 << (59 - F))) >> (60 - F));
  localparam logic signed [W-1:0] PI_FS = W'(PI_F);
  localparam logic signed [W-1:0] ONE   = W'(64'd1 << F);
  localparam logic [27:0] K_HI = 28'(gcd_pkg::RAD_PER_UNIT >> 29);
  localparam logic [28:0] K_LO = 29'(gcd_pkg::RAD_PER_UNIT);
  localparam logic [80:0] Z_RND = 81'd1 << (77 - F);
  localparam logic [PW-1:0] P_RND = PW'(1) << (F - 1);
  localparam logic signed [25:0] HALF    = 26'(gcd_pkg::DEG_HALF);
  localparam logic signed [25:0] FULL    = 26'(gcd_pkg::DEG_FULL);
  localparam logic signed [25:0] QUARTER = 26'(gcd_pkg::DEG_QUARTER);

  typedef struct packed {
    logic        flip;
    logic        neg;
    logic [22:0] mag;
  } fold_t;

  // wrap into (-180, 180], fold into [-90, 90]; flip negates the cosine
  function automatic fold_t fold(input logic signed [25:0] a);
    logic signed [25:0] d;
    fold_t r;
    d = a;
    r.flip = 1'b0;
    if (d > HALF) d = d - FULL;
    if (d <= -HALF) d = d + FULL;
    if (d > QUARTER) begin
      d = HALF - d;
      r.flip = 1'b1;
    end
    if (d < -QUARTER) begin
      d = -HALF - d;
      r.flip = 1'b1;
    end
    r.neg = d[25];
    r.mag = 23'(d[25] ? -d : d);
    return r;
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic signed [W-1:0] v);
    return MW'(v[W-1] ? -v : v);
  endfunction

  // square of the magnitude of the clamped dot product
  function automatic logic [SW-1:0] mag_sq(input logic signed [W-1:0] d);
    logic [RW-1:0] u;
    u = RW'(d[W-1] ? -d : d);
    return SW'(u) * SW'(u);
  endfunction

  logic adv;
  logic accept;
  logic out_valid_r;
  logic [39:0] out_tdata_r;
  logic [31:0] radius_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign accept     = in_tvalid && adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 32'd1621555;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  // ---------------- angle folding and degree to radian scaling
  logic signed [25:0] ang_in [4];
  assign ang_in[0] = 26'(signed'(in_tdata[23:0]));
  assign ang_in[1] = 26'(signed'(in_tdata[48:24]));
  assign ang_in[2] = 26'(signed'(in_tdata[72:49]));
  assign ang_in[3] = 26'(signed'(in_tdata[97:73]));

  fold_t fold_r [4];
  logic  v0_r, same0_r;
  logic [50:0] ph_r [4];
  logic [51:0] pl_r [4];
  logic  neg1_r [4];
  logic  flip1_r [4];
  logic  v1_r, same1_r;
  logic signed [W-1:0] z2_r [4];
  logic  flip2_r [4];
  logic  v2_r, same2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      same0_r <= (in_tdata[23:0] == in_tdata[72:49]) && (in_tdata[48:24] == in_tdata[97:73]);
      same1_r <= same0_r;
      same2_r <= same1_r;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_scale
    logic [80:0]         zsum;
    logic signed [W-1:0] zmag;

    assign zsum = {1'b0, ph_r[j], 29'b0} + {29'b0, pl_r[j]} + Z_RND;
    assign zmag = W'(zsum >> (78 - F));

    always_ff @(posedge clk) begin
      if (adv) begin
        fold_r[j]  <= fold(ang_in[j]);
        ph_r[j]    <= fold_r[j].mag * K_HI;
        pl_r[j]    <= fold_r[j].mag * K_LO;
        neg1_r[j]  <= fold_r[j].neg;
        flip1_r[j] <= fold_r[j].flip;
        z2_r[j]    <= neg1_r[j] ? -zmag : zmag;
        flip2_r[j] <= flip1_r[j];
      end
    end
  end

  // ---------------- four sine/cosine units: 0 lat_a, 1 lon_a, 2 lat_b, 3 lon_b
  logic                rv [4];
  logic [1:0]          rt [4];
  logic signed [W-1:0] rx [4];
  logic signed [W-1:0] ry [4];
  logic signed [W-1:0] cs [4];

  for (genvar j = 0; j < 4; j++) begin : g_trig
    gcd_cordic #(
      .F(F), .N(N), .W(W), .TW(2), .VECTOR(1'b0)
    ) u_rot (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (v2_r),
      .tag_i ({same2_r, flip2_r[j]}),
      .x_i   (GAIN),
      .y_i   ('0),
      .z_i   (z2_r[j]),
      .vld_o (rv[j]),
      .tag_o (rt[j]),
      .x_o   (rx[j]),
      .y_o   (ry[j]),
      .z_o   ()
    );
    assign cs[j] = rt[j][0] ? -rx[j] : rx[j];
  end

  // ---------------- dot product of the two unit vectors
  logic signed [W-1:0] opa [5];
  logic signed [W-1:0] opb [5];
  assign opa[0] = cs[1]; assign opb[0] = cs[0];
  assign opa[1] = ry[1]; assign opb[1] = cs[0];
  assign opa[2] = cs[3]; assign opb[2] = cs[2];
  assign opa[3] = ry[3]; assign opb[3] = cs[2];
  assign opa[4] = ry[0]; assign opb[4] = ry[2];

  logic [PW-1:0]       m1_r [5];
  logic                sg1_r [5];
  logic signed [W-1:0] t2_r [5];
  logic [PW-1:0]       m3_r [2];
  logic                sg3_r [2];
  logic signed [W-1:0] t3_r;
  logic signed [W-1:0] d4_r;
  logic v4_r [4];
  logic s4_r [4];

  for (genvar j = 0; j < 5; j++) begin : g_dot1
    logic [PW-1:0]       rnd;
    logic signed [W-1:0] tm;
    assign rnd = m1_r[j] + P_RND;
    assign tm  = W'(rnd >> F);
    always_ff @(posedge clk) begin
      if (adv) begin
        m1_r[j]  <= mag_of(opa[j]) * mag_of(opb[j]);
        sg1_r[j] <= opa[j][W-1] ^ opb[j][W-1];
        t2_r[j]  <= sg1_r[j] ? -tm : tm;
      end
    end
  end

  logic signed [W-1:0] u4 [2];
  for (genvar j = 0; j < 2; j++) begin : g_dot2
    logic [PW-1:0]       rnd;
    logic signed [W-1:0] um;
    assign rnd   = m3_r[j] + P_RND;
    assign um    = W'(rnd >> F);
    assign u4[j] = sg3_r[j] ? -um : um;
    always_ff @(posedge clk) begin
      if (adv) begin
        m3_r[j]  <= mag_of(t2_r[j]) * mag_of(t2_r[j+2]);
        sg3_r[j] <= t2_r[j][W-1] ^ t2_r[j+2][W-1];
      end
    end
  end

  logic signed [W-1:0] dot_sum;
  assign dot_sum = u4[0] + u4[1] + t3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_r <= t2_r[4];
      if (dot_sum > ONE) begin
        d4_r <= ONE;
      end else if (dot_sum < -ONE) begin
        d4_r <= -ONE;
      end else begin
        d4_r <= dot_sum;
      end
    end
  end

  // valid and same flag through the four dot product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) v4_r[k] <= 1'b0;
    end else if (adv) begin
      v4_r[0] <= rv[0];
      for (int k = 1; k < 4; k++) v4_r[k] <= v4_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r[0] <= rt[0][1];
      for (int k = 1; k < 4; k++) s4_r[k] <= s4_r[k-1];
    end
  end

  // ---------------- acos: sqrt(1 - d^2) then atan2 by vectoring
  logic [RW-1:0] ud_a1_r;
  logic          neg_a1_r, v_a1_r, s_a1_r;
  logic [SW-1:0] sq_a1_r;
  logic [RW-1:0] ud_a2_r;
  logic          neg_a2_r, v_a2_r, s_a2_r;
  logic [SW-1:0] rem_a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a1_r <= 1'b0;
      v_a2_r <= 1'b0;
    end else if (adv) begin
      v_a1_r <= v4_r[3];
      v_a2_r <= v_a1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ud_a1_r  <= RW'(d4_r[W-1] ? -d4_r : d4_r);
      neg_a1_r <= d4_r[W-1];
      s_a1_r   <= s4_r[3];
      sq_a1_r  <= mag_sq(d4_r);
      ud_a2_r  <= ud_a1_r;
      neg_a2_r <= neg_a1_r;
      s_a2_r   <= s_a1_r;
      rem_a2_r <= (SW'(1) << (2 * F)) - sq_a1_r;
    end
  end

  // one root bit per stage, most significant first
  logic [SW-1:0] sr_rem_r  [RW];
  logic [RW-1:0] sr_root_r [RW];
  logic [RW-1:0] sr_ud_r   [RW];
  logic          sr_neg_r  [RW];
  logic          sr_s_r    [RW];
  logic          sr_v_r    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = F - k;
    logic [SW-1:0] rem_p;
    logic [RW-1:0] root_p, ud_p;
    logic          neg_p, s_p, v_p;
    logic [SW-1:0] trial;

    if (k == 0) begin : g_head
      assign rem_p  = rem_a2_r;
      assign root_p = '0;
      assign ud_p   = ud_a2_r;
      assign neg_p  = neg_a2_r;
      assign s_p    = s_a2_r;
      assign v_p    = v_a2_r;
    end else begin : g_link
      assign rem_p  = sr_rem_r[k-1];
      assign root_p = sr_root_r[k-1];
      assign ud_p   = sr_ud_r[k-1];
      assign neg_p  = sr_neg_r[k-1];
      assign s_p    = sr_s_r[k-1];
      assign v_p    = sr_v_r[k-1];
    end

    assign trial = (SW'(root_p) << (B + 1)) | (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_p >= trial) begin
          sr_rem_r[k]  <= rem_p - trial;
          sr_root_r[k] <= root_p | (RW'(1) << B);
        end else begin
          sr_rem_r[k]  <= rem_p;
          sr_root_r[k] <= root_p;
        end
        sr_ud_r[k]  <= ud_p;
        sr_neg_r[k] <= neg_p;
        sr_s_r[k]   <= s_p;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[k] <= 1'b0;
      end else if (adv) begin
        sr_v_r[k] <= v_p;
      end
    end
  end

  logic                vv;
  logic [1:0]          vt;
  logic signed [W-1:0] vz;

  gcd_cordic #(
    .F(F), .N(N), .W(W), .TW(2), .VECTOR(1'b1)
  ) u_vec (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (sr_v_r[RW-1]),
    .tag_i ({sr_s_r[RW-1], sr_neg_r[RW-1]}),
    .x_i   (W'(sr_ud_r[RW-1])),
    .y_i   (W'(sr_root_r[RW-1])),
    .z_i   ('0),
    .vld_o (vv),
    .tag_o (vt),
    .x_o   (),
    .y_o   (),
    .z_o   (vz)
  );

  // ---------------- clamp angle, scale by radius, round
  logic [AW-1:0] zc;
  logic [AW-1:0] ang_e1_r;
  logic          v_e1_r, s_e1_r;
  logic [AW+31:0] prod_e2_r;
  logic          v_e2_r, s_e2_r;
  logic [AW+31:0] prod_rnd;

  always_comb begin
    if (vz[W-1]) begin
      zc = '0;
    end else if (vz > PI_FS) begin
      zc = PI_F;
    end else begin
      zc = AW'(vz);
    end
  end

  assign prod_rnd = prod_e2_r + ((AW + 32)'(1) << (F - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_e1_r    <= vt[0] ? PI_F - zc : zc;
      s_e1_r      <= vt[1];
      prod_e2_r   <= radius_r * ang_e1_r;
      s_e2_r      <= s_e1_r;
      out_tdata_r <= s_e2_r ? 40'd0 : {6'b0, 34'(prod_rnd >> F)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e1_r      <= 1'b0;
      v_e2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_e1_r      <= vv;
      v_e2_r      <= v_e1_r;
      out_valid_r <= v_e2_r;
    end
  end

endmodule
